// ===== rtl/sph_pkg.sv =====
package sph_pkg;

    localparam int MAX_DIM      = 1024;
    localparam int FRAC_BITS    = 16;
    localparam int NUM_BINS     = 10;
    localparam int BIN_W        = 40;
    localparam int VALUE_W      = 24;
    localparam int OFFSET_W     = 10;
    localparam int CFG_W        = 11;
    localparam int SHARE_TOTAL  = 200;
    localparam int POS_SCALE    = 10;
    localparam int REM_SCALE    = 30;
    localparam int RECIP_MUL    = 6554;
    localparam int RECIP_SHIFT  = 16;

    localparam int DIM_W    = $clog2(MAX_DIM + 1);
    localparam int EXT_W    = ((CFG_W > DIM_W) ? CFG_W : DIM_W) + 2;
    localparam int ACC_W    = $clog2(POS_SCALE * (2 ** OFFSET_W) + 1);
    localparam int AMT_W    = DIM_W + 2;
    localparam int IDX_W    = $clog2(NUM_BINS);
    localparam int FEAT_W   = $clog2(2 * NUM_BINS);
    localparam int SUM_W    = BIN_W + $clog2(NUM_BINS);
    localparam int SPAN_W   = DIM_W + 1;
    localparam int SCALE_W  = $clog2(SHARE_TOTAL * MAX_DIM + 1);
    localparam int PROD_W   = BIN_W + SCALE_W;
    localparam int NUM_W    = PROD_W + FRAC_BITS;
    localparam int HI_W     = NUM_W - VALUE_W;
    localparam int DEN_W    = SUM_W + SPAN_W;
    localparam int SUB_W    = (DEN_W + 1 > HI_W) ? DEN_W + 1 : HI_W;
    localparam int CNT_W    = $clog2(VALUE_W);
    localparam int RQ_W     = DIM_W + RECIP_SHIFT;

    localparam int LAST_BIN     = NUM_BINS - 1;
    localparam int LAST_FEATURE = 2 * NUM_BINS - 1;

    typedef enum logic [0:0] {
        REG_BOX_HEIGHT = 1'b0,
        REG_BOX_WIDTH  = 1'b1
    } sph_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BIN_DIV,
        ST_BIN_REM,
        ST_BIN_ADD0,
        ST_BIN_ADD1,
        ST_SUM,
        ST_FEAT_MUL,
        ST_FEAT_CHK,
        ST_FEAT_DIV,
        ST_OUT
    } sph_state_t;

    typedef struct packed {
        logic             add;
        logic             clr;
        logic [IDX_W-1:0] idx;
        logic [AMT_W-1:0] amt;
    } sph_bank_ctl_t;

endpackage

// ===== rtl/sph_bin_bank.sv =====
module sph_bin_bank (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  sph_pkg::sph_bank_ctl_t       ctl,
    output logic [sph_pkg::BIN_W-1:0]    rd_data
);

    localparam int BIN_W    = sph_pkg::BIN_W;
    localparam int NUM_BINS = sph_pkg::NUM_BINS;

    logic [BIN_W-1:0] bins_reg [NUM_BINS];
    logic [BIN_W:0]   add_sum;
    logic [BIN_W-1:0] bin_next;

    assign rd_data = bins_reg[ctl.idx];

    // Bins saturate rather than wrap.
    always_comb begin
        add_sum  = {1'b0, rd_data} + (BIN_W + 1)'(ctl.amt);
        bin_next = add_sum[BIN_W] ? '1 : add_sum[BIN_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clr) begin
            for (int i = 0; i < NUM_BINS; i++) begin
                bins_reg[i] <= '0;
            end
        end else if (ctl.add) begin
            bins_reg[ctl.idx] <= bin_next;
        end
    end

endmodule

// ===== rtl/soft_projection_histogram_core.sv =====
// Pixel item: one that adds nothing skips the bin steps; otherwise per axis (row, then
// column) the coarse bin 0..9 is found by repeated subtraction, then one or two bins are added.
// Last pixel: the bins are totalled, then per feature a multiply, a check and up to 24
// bits of bit-serial division in the shared subtractor, plus the wait on m_ready.
// One item is in flight at a time; s_ready is high only while the sequencer is idle.
// Synchronous active-low reset clears all bins and sets both box sizes to 1.
module soft_projection_histogram_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [sph_pkg::OFFSET_W-1:0]    s_row_offset,
    input  logic [sph_pkg::OFFSET_W-1:0]    s_col_offset,
    input  logic                            s_foreground,
    input  logic                            s_last_pixel,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [sph_pkg::FEAT_W-1:0]      m_feature_index,
    output logic [sph_pkg::VALUE_W-1:0]     m_feature_value,
    output logic                            m_last_feature,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [0:0]                      cfg_index,
    input  logic [sph_pkg::CFG_W-1:0]       cfg_data
);

    localparam int MAX_DIM     = sph_pkg::MAX_DIM;
    localparam int FRAC_BITS   = sph_pkg::FRAC_BITS;
    localparam int NUM_BINS    = sph_pkg::NUM_BINS;
    localparam int BIN_W       = sph_pkg::BIN_W;
    localparam int VALUE_W     = sph_pkg::VALUE_W;
    localparam int OFFSET_W    = sph_pkg::OFFSET_W;
    localparam int CFG_W       = sph_pkg::CFG_W;
    localparam int DIM_W       = sph_pkg::DIM_W;
    localparam int EXT_W       = sph_pkg::EXT_W;
    localparam int ACC_W       = sph_pkg::ACC_W;
    localparam int AMT_W       = sph_pkg::AMT_W;
    localparam int IDX_W       = sph_pkg::IDX_W;
    localparam int FEAT_W      = sph_pkg::FEAT_W;
    localparam int SUM_W       = sph_pkg::SUM_W;
    localparam int SPAN_W      = sph_pkg::SPAN_W;
    localparam int SCALE_W     = sph_pkg::SCALE_W;
    localparam int PROD_W      = sph_pkg::PROD_W;
    localparam int NUM_W       = sph_pkg::NUM_W;
    localparam int HI_W        = sph_pkg::HI_W;
    localparam int DEN_W       = sph_pkg::DEN_W;
    localparam int SUB_W       = sph_pkg::SUB_W;
    localparam int CNT_W       = sph_pkg::CNT_W;
    localparam int RQ_W        = sph_pkg::RQ_W;
    localparam int RECIP_SHIFT = sph_pkg::RECIP_SHIFT;

    sph_pkg::sph_state_t state_reg, state_next;

    logic [CFG_W-1:0]    box_height_reg, box_width_reg;
    logic [DIM_W-1:0]    h_sat, w_sat, dim_sel;

    logic                sel_col_reg, sel_col_next;
    logic                last_reg, last_next;
    logic [OFFSET_W-1:0] col_pos_reg, col_pos_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [IDX_W-1:0]    q_reg, q_next;
    logic [IDX_W-1:0]    idx0_reg, idx0_next, idx1_reg, idx1_next;
    logic [AMT_W-1:0]    amt0_reg, amt0_next, amt1_reg, amt1_next;
    logic                two_reg, two_next;
    logic [SUM_W-1:0]    sum_r_reg, sum_r_next, sum_c_reg, sum_c_next;
    logic [IDX_W-1:0]    k_reg, k_next;
    logic [SCALE_W-1:0]  scale_c_reg, scale_c_next, scale_r_reg, scale_r_next;
    logic [SPAN_W-1:0]   span_reg, span_next;
    logic [FEAT_W-1:0]   feat_reg, feat_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [DEN_W-1:0]    den_reg, den_next;
    logic [DEN_W-1:0]    rem_reg, rem_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [VALUE_W-1:0]  value_reg, value_next;

    logic                qualify, bin_done, feat_col, feat_last;
    logic [IDX_W-1:0]    feat_idx;
    logic [BIN_W-1:0]    row_rd, col_rd, feat_bin;
    logic [NUM_W-1:0]    num_full;
    logic [HI_W-1:0]     num_hi;
    logic [VALUE_W-1:0]  num_lo;
    logic [SUB_W-1:0]    sub_a, sub_b, sub_diff;
    logic                sub_borrow, sub_ge;
    logic [RQ_W-1:0]     rq_prod;
    logic [AMT_W-1:0]    rem_v, t_v, dim_a, dim2, dim4;

    sph_pkg::sph_bank_ctl_t row_ctl, col_ctl;

    sph_bin_bank u_row_bank (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (row_ctl),
        .rd_data (row_rd)
    );

    sph_bin_bank u_col_bank (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (col_ctl),
        .rd_data (col_rd)
    );

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_height_reg <= CFG_W'(1);
            box_width_reg  <= CFG_W'(1);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                sph_pkg::REG_BOX_HEIGHT: box_height_reg <= cfg_data;
                sph_pkg::REG_BOX_WIDTH:  box_width_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        h_sat = (EXT_W'(box_height_reg) > EXT_W'(MAX_DIM)) ? DIM_W'(MAX_DIM)
                                                            : DIM_W'(box_height_reg);
        w_sat = (EXT_W'(box_width_reg) > EXT_W'(MAX_DIM)) ? DIM_W'(MAX_DIM)
                                                           : DIM_W'(box_width_reg);
        dim_sel = sel_col_reg ? w_sat : h_sat;
        qualify = s_foreground
                  && (EXT_W'(s_row_offset) + EXT_W'(2) <= EXT_W'(h_sat))
                  && (EXT_W'(s_col_offset) + EXT_W'(2) <= EXT_W'(w_sat));
        bin_done = ((state_reg == sph_pkg::ST_BIN_ADD0) && !two_reg)
                   || (state_reg == sph_pkg::ST_BIN_ADD1);
        feat_col  = (feat_reg < FEAT_W'(NUM_BINS));
        feat_idx  = feat_col ? IDX_W'(feat_reg) : IDX_W'(feat_reg - FEAT_W'(NUM_BINS));
        feat_bin  = feat_col ? col_rd : row_rd;
        feat_last = (feat_reg == FEAT_W'(sph_pkg::LAST_FEATURE));
        num_full  = {prod_reg, {FRAC_BITS{1'b0}}};
        num_hi    = num_full[NUM_W-1:VALUE_W];
        num_lo    = num_full[VALUE_W-1:0];
    end

    // The one subtract-and-compare unit, shared by the coarse bin search and by the
    // overflow check and restoring division of each feature.
    always_comb begin
        unique case (state_reg)
            sph_pkg::ST_BIN_DIV: begin
                sub_a = SUB_W'(acc_reg);
                sub_b = SUB_W'(dim_sel);
            end
            sph_pkg::ST_FEAT_CHK: begin
                sub_a = SUB_W'(num_hi);
                sub_b = SUB_W'(den_reg);
            end
            default: begin
                sub_a = SUB_W'({rem_reg, num_lo[cnt_reg]});
                sub_b = SUB_W'(den_reg);
            end
        endcase
        {sub_borrow, sub_diff} = {1'b0, sub_a} - {1'b0, sub_b};
        sub_ge = !sub_borrow;
    end

    // Remainder within the coarse bin and the split of the pixel's weight.
    always_comb begin
        rq_prod = RQ_W'(acc_reg[DIM_W-1:0]) * RQ_W'(sph_pkg::RECIP_MUL);
        rem_v   = AMT_W'(rq_prod >> RECIP_SHIFT);
        t_v     = AMT_W'(rem_v * AMT_W'(sph_pkg::REM_SCALE));
        dim_a   = AMT_W'(dim_sel);
        dim2    = dim_a << 1;
        dim4    = dim_a << 2;
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg) inside
            sph_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (qualify) begin
                        state_next = sph_pkg::ST_BIN_DIV;
                    end else if (s_last_pixel) begin
                        state_next = sph_pkg::ST_SUM;
                    end
                end
            end
            sph_pkg::ST_BIN_DIV: begin
                if (!sub_ge) begin
                    state_next = sph_pkg::ST_BIN_REM;
                end
            end
            sph_pkg::ST_BIN_REM: state_next = sph_pkg::ST_BIN_ADD0;
            sph_pkg::ST_BIN_ADD0, sph_pkg::ST_BIN_ADD1: begin
                if (!bin_done) begin
                    state_next = sph_pkg::ST_BIN_ADD1;
                end else if (!sel_col_reg) begin
                    state_next = sph_pkg::ST_BIN_DIV;
                end else if (last_reg) begin
                    state_next = sph_pkg::ST_SUM;
                end else begin
                    state_next = sph_pkg::ST_IDLE;
                end
            end
            sph_pkg::ST_SUM: begin
                if (k_reg == IDX_W'(sph_pkg::LAST_BIN)) begin
                    state_next = sph_pkg::ST_FEAT_MUL;
                end
            end
            sph_pkg::ST_FEAT_MUL: state_next = sph_pkg::ST_FEAT_CHK;
            sph_pkg::ST_FEAT_CHK: begin
                if (den_reg == '0 || sub_ge) begin
                    state_next = sph_pkg::ST_OUT;
                end else begin
                    state_next = sph_pkg::ST_FEAT_DIV;
                end
            end
            sph_pkg::ST_FEAT_DIV: begin
                if (cnt_reg == '0) begin
                    state_next = sph_pkg::ST_OUT;
                end
            end
            sph_pkg::ST_OUT: begin
                if (m_ready) begin
                    state_next = feat_last ? sph_pkg::ST_IDLE : sph_pkg::ST_FEAT_MUL;
                end
            end
            default: state_next = sph_pkg::ST_IDLE;
        endcase
    end

    // Outputs and bin bank control.
    always_comb begin
        s_ready = (state_reg == sph_pkg::ST_IDLE);
        m_valid = (state_reg == sph_pkg::ST_OUT);
        row_ctl = '0;
        col_ctl = '0;
        unique case (state_reg) inside
            sph_pkg::ST_BIN_ADD0, sph_pkg::ST_BIN_ADD1: begin
                row_ctl.idx = (state_reg == sph_pkg::ST_BIN_ADD0) ? idx0_reg : idx1_reg;
                row_ctl.amt = (state_reg == sph_pkg::ST_BIN_ADD0) ? amt0_reg : amt1_reg;
                col_ctl.idx = row_ctl.idx;
                col_ctl.amt = row_ctl.amt;
                row_ctl.add = !sel_col_reg;
                col_ctl.add = sel_col_reg;
            end
            sph_pkg::ST_SUM: begin
                row_ctl.idx = k_reg;
                col_ctl.idx = k_reg;
            end
            sph_pkg::ST_OUT: begin
                row_ctl.clr = m_ready && feat_last;
                col_ctl.clr = m_ready && feat_last;
                row_ctl.idx = feat_idx;
                col_ctl.idx = feat_idx;
            end
            default: begin
                row_ctl.idx = feat_idx;
                col_ctl.idx = feat_idx;
            end
        endcase
    end

    assign m_feature_index = feat_reg;
    assign m_feature_value = value_reg;
    assign m_last_feature  = feat_last;

    // Datapath next values.
    always_comb begin
        sel_col_next = sel_col_reg;
        last_next    = last_reg;
        col_pos_next = col_pos_reg;
        acc_next     = acc_reg;
        q_next       = q_reg;
        idx0_next    = idx0_reg;
        idx1_next    = idx1_reg;
        amt0_next    = amt0_reg;
        amt1_next    = amt1_reg;
        two_next     = two_reg;
        sum_r_next   = sum_r_reg;
        sum_c_next   = sum_c_reg;
        k_next       = k_reg;
        scale_c_next = scale_c_reg;
        scale_r_next = scale_r_reg;
        span_next    = span_reg;
        feat_next    = feat_reg;
        prod_next    = prod_reg;
        den_next     = den_reg;
        rem_next     = rem_reg;
        cnt_next     = cnt_reg;
        value_next   = value_reg;

        unique case (state_reg) inside
            sph_pkg::ST_IDLE: begin
                sel_col_next = 1'b0;
                last_next    = s_last_pixel;
                col_pos_next = s_col_offset;
                acc_next     = ACC_W'(s_row_offset) * ACC_W'(sph_pkg::POS_SCALE);
                q_next       = '0;
                sum_r_next   = '0;
                sum_c_next   = '0;
                k_next       = '0;
            end
            sph_pkg::ST_BIN_DIV: begin
                if (sub_ge) begin
                    acc_next = ACC_W'(sub_diff);
                    q_next   = q_reg + IDX_W'(1);
                end
            end
            sph_pkg::ST_BIN_REM: begin
                two_next  = 1'b0;
                idx0_next = q_reg;
                amt0_next = dim2;
                idx1_next = q_reg;
                amt1_next = dim2;
                if (t_v < dim_a) begin
                    if (q_reg != '0) begin
                        two_next  = 1'b1;
                        idx0_next = q_reg - IDX_W'(1);
                        amt0_next = dim_a - t_v;
                        amt1_next = dim_a + t_v;
                    end
                end else if (t_v > dim2 && q_reg < IDX_W'(sph_pkg::LAST_BIN)) begin
                    two_next  = 1'b1;
                    idx0_next = q_reg + IDX_W'(1);
                    amt0_next = t_v - dim2;
                    amt1_next = dim4 - t_v;
                end
            end
            sph_pkg::ST_BIN_ADD0, sph_pkg::ST_BIN_ADD1: begin
                if (bin_done) begin
                    sel_col_next = 1'b1;
                    acc_next     = ACC_W'(col_pos_reg) * ACC_W'(sph_pkg::POS_SCALE);
                    q_next       = '0;
                    sum_r_next   = '0;
                    sum_c_next   = '0;
                    k_next       = '0;
                end
            end
            sph_pkg::ST_SUM: begin
                sum_r_next   = sum_r_reg + SUM_W'(row_rd);
                sum_c_next   = sum_c_reg + SUM_W'(col_rd);
                k_next       = k_reg + IDX_W'(1);
                scale_c_next = SCALE_W'(SCALE_W'(sph_pkg::SHARE_TOTAL) * SCALE_W'(h_sat));
                scale_r_next = SCALE_W'(SCALE_W'(sph_pkg::SHARE_TOTAL) * SCALE_W'(w_sat));
                span_next    = SPAN_W'(h_sat) + SPAN_W'(w_sat);
                feat_next    = '0;
            end
            sph_pkg::ST_FEAT_MUL: begin
                prod_next = PROD_W'(feat_bin) * PROD_W'(feat_col ? scale_c_reg : scale_r_reg);
                den_next  = DEN_W'(feat_col ? sum_c_reg : sum_r_reg) * DEN_W'(span_reg);
            end
            sph_pkg::ST_FEAT_CHK: begin
                // A quotient of 2^VALUE_W or more saturates; an empty group gives zero.
                rem_next   = DEN_W'(num_hi);
                cnt_next   = CNT_W'(VALUE_W - 1);
                value_next = (den_reg != '0 && sub_ge) ? '1 : '0;
            end
            sph_pkg::ST_FEAT_DIV: begin
                rem_next   = sub_ge ? DEN_W'(sub_diff) : DEN_W'(sub_a);
                value_next = {value_reg[VALUE_W-2:0], sub_ge};
                cnt_next   = cnt_reg - CNT_W'(1);
            end
            sph_pkg::ST_OUT: begin
                if (m_ready) begin
                    feat_next = feat_reg + FEAT_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sph_pkg::ST_IDLE;
            sel_col_reg <= 1'b0;
            last_reg    <= 1'b0;
            feat_reg    <= '0;
            k_reg       <= '0;
            q_reg       <= '0;
            cnt_reg     <= '0;
            two_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sel_col_reg <= sel_col_next;
            last_reg    <= last_next;
            feat_reg    <= feat_next;
            k_reg       <= k_next;
            q_reg       <= q_next;
            cnt_reg     <= cnt_next;
            two_reg     <= two_next;
        end
    end

    always_ff @(posedge aclk) begin
        col_pos_reg <= col_pos_next;
        acc_reg     <= acc_next;
        idx0_reg    <= idx0_next;
        idx1_reg    <= idx1_next;
        amt0_reg    <= amt0_next;
        amt1_reg    <= amt1_next;
        sum_r_reg   <= sum_r_next;
        sum_c_reg   <= sum_c_next;
        scale_c_reg <= scale_c_next;
        scale_r_reg <= scale_r_next;
        span_reg    <= span_next;
        prod_reg    <= prod_next;
        den_reg     <= den_next;
        rem_reg     <= rem_next;
        value_reg   <= value_next;
    end

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("Input accepted while a feature item is pending.");

    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_feature |-> m_feature_index == FEAT_W'(sph_pkg::LAST_FEATURE))
        else $error("Last feature flag on the wrong index.");

    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == sph_pkg::ST_FEAT_DIV |-> den_reg != '0)
        else $error("Division entered with a zero divisor.");

    a_bin_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == sph_pkg::ST_BIN_DIV |-> q_reg < IDX_W'(NUM_BINS))
        else $error("Coarse bin search ran past the last bin.");

    a_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last_feature |=> s_ready)
        else $error("Block not idle after the last feature item.");

endmodule
